// ===== rtl/ddo_pkg.sv =====
// Shared types and constants for the differential drive odometry block.
package ddo_pkg;

    localparam int FRAC_BITS_DEF    = 16;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int SH_LIN           = 36;
    localparam int SH_TURN          = 20;

    localparam logic [63:0] PI_Q60       = 64'h3243F6A8885A308D;
    localparam logic [19:0] USEC_PER_SEC = 20'd1000000;

    typedef logic signed [33:0] crd_t;
    typedef logic [63:0]        mop_t;
    typedef logic [127:0]       mprod_t;

    typedef enum logic [1:0] {
        REG_TICKS    = 2'd0,
        REG_RADIUS_R = 2'd1,
        REG_RADIUS_L = 2'd2,
        REG_TREAD    = 2'd3
    } reg_idx_t;

    localparam crd_t GAIN_Q30 = 34'sd652032874;

    localparam logic [31:0] ATAN_BAM [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
        32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
        32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000
    };

endpackage

// ===== rtl/ddo_mul.sv =====
// Shared 64 by 64 bit multiplier built from four 32 by 32 bit partial products.
module ddo_mul
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  ddo_pkg::mop_t   a,
    input  ddo_pkg::mop_t   b,
    input  ddo_pkg::mprod_t init,
    output ddo_pkg::mprod_t prod,
    output logic            done
);

    logic [2:0]      cnt_reg;
    logic            busy_reg;
    logic            done_reg;
    logic [63:0]     pp_reg;
    logic [1:0]      sh_reg;
    ddo_pkg::mprod_t acc_reg;
    logic [31:0]     a_part;
    logic [31:0]     b_part;

    always_comb
    begin
        a_part = cnt_reg[0] ? a[63:32] : a[31:0];
        b_part = cnt_reg[1] ? b[63:32] : b[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 3'd0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= 3'd0;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 3'd1;
            if (cnt_reg == 3'd4)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= init;
        end
        else if (busy_reg)
        begin
            if (cnt_reg != 3'd4)
            begin
                pp_reg <= a_part * b_part;
                sh_reg <= {1'b0, cnt_reg[0]} + {1'b0, cnt_reg[1]};
            end
            if (cnt_reg != 3'd0)
            begin
                acc_reg <= acc_reg + (128'(pp_reg) << {sh_reg, 5'b0});
            end
        end
    end

    assign prod = acc_reg;
    assign done = done_reg;

endmodule

// ===== rtl/ddo_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
module ddo_div #(
    parameter int NUM_W = 92
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  ddo_pkg::mop_t    den,
    output logic [NUM_W-1:0] quo,
    output logic             done
);

    localparam int CNT_W = $clog2(NUM_W);

    logic [63:0]      rem_reg;
    logic [NUM_W-1:0] num_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [64:0]      trial;
    logic [64:0]      diff;
    logic             fits;

    always_comb
    begin
        trial = {rem_reg, num_reg[NUM_W-1]};
        diff  = trial - {1'b0, den};
        fits  = (trial >= {1'b0, den});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(NUM_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= 64'd0;
            num_reg <= num;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[63:0] : trial[63:0];
            num_reg <= num_reg << 1;
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
        end
    end

    assign quo  = quo_reg;
    assign done = done_reg;

endmodule

// ===== rtl/ddo_cordic.sv =====
// Iterative CORDIC that yields cosine and sine of a binary angle in Q30.
module ddo_cordic #(
    parameter int STEPS = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [31:0]   heading,
    output ddo_pkg::crd_t cs,
    output ddo_pkg::crd_t sn,
    output logic          done
);

    localparam int CW = $clog2(STEPS + 1);
    localparam ddo_pkg::crd_t QUARTER = 34'sd1073741824;
    localparam ddo_pkg::crd_t HALF    = 34'sd2147483648;

    ddo_pkg::crd_t x_reg;
    ddo_pkg::crd_t y_reg;
    ddo_pkg::crd_t z_reg;
    logic          flip_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    ddo_pkg::crd_t z0;
    ddo_pkg::crd_t zf;
    logic          flip_c;
    ddo_pkg::crd_t xs;
    ddo_pkg::crd_t ys;
    ddo_pkg::crd_t at;
    logic [4:0]    idx;

    always_comb
    begin
        z0     = {{2{heading[31]}}, heading};
        zf     = z0;
        flip_c = 1'b0;
        if (z0 > QUARTER)
        begin
            zf     = z0 - HALF;
            flip_c = 1'b1;
        end
        else if (z0 < -QUARTER)
        begin
            zf     = z0 + HALF;
            flip_c = 1'b1;
        end
        idx = 5'(cnt_reg);
        xs  = x_reg >>> cnt_reg;
        ys  = y_reg >>> cnt_reg;
        at  = $signed({2'b00, ddo_pkg::ATAN_BAM[idx]});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == CW'(STEPS))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= ddo_pkg::GAIN_Q30;
            y_reg    <= '0;
            z_reg    <= zf;
            flip_reg <= flip_c;
        end
        else if (busy_reg && (cnt_reg != CW'(STEPS)))
        begin
            if (!z_reg[33])
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - at;
            end
            else
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + at;
            end
        end
    end

    assign cs   = flip_reg ? -x_reg : x_reg;
    assign sn   = flip_reg ? -y_reg : y_reg;
    assign done = done_reg;

endmodule

// ===== rtl/differential_drive_odometry.sv =====
// Each result takes longer when the interval is nonzero, since speed and turn rate then need extra
// products and divisions; the one-bit-per-cycle divider accounts for most of the processing time.
// Throughput: one item at a time; the next item is taken once the result sits in the output.
// Reset clears the pose, loads the default wheel geometry and leaves no result pending.
module differential_drive_odometry #(
    parameter int FRAC_BITS    = ddo_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [55:0]  s_tdata,   // left_count, right_count, interval_us, zero fill
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [159:0] m_tdata    // pos_x, pos_y, heading, linear_speed, turn_rate
);

    localparam int NUM_W = FRAC_BITS + 76;
    localparam logic [63:0] PIF =
        (ddo_pkg::PI_Q60 + (64'd1 << (39 - FRAC_BITS))) >> (40 - FRAC_BITS);
    localparam logic [63:0] PIF2 = PIF << 1;

    typedef enum logic [4:0] {
        ST_IDLE, ST_MUL_R, ST_MUL_L, ST_SUMS, ST_DIST_MUL, ST_DIST_DIV, ST_PT_MUL,
        ST_BAM_DIV, ST_PD_MUL, ST_AV_MUL, ST_V_MUL, ST_V_DIV, ST_PTD_MUL, ST_AW_MUL,
        ST_W_MUL, ST_W_DIV, ST_CORDIC, ST_X_MUL, ST_Y_MUL, ST_OUT
    } state_t;

    state_t             state_reg;
    logic [23:0]        ticks_reg;
    logic [15:0]        rad_r_reg;
    logic [15:0]        rad_l_reg;
    logic [19:0]        tread_reg;

    logic               cl_neg_reg;
    logic               cr_neg_reg;
    logic [15:0]        cl_mag_reg;
    logic [19:0]        dt_reg;
    logic [23:0]        p_reg;
    logic [19:0]        t_reg;
    logic [31:0]        ar_reg;
    logic [31:0]        dmag_reg;
    logic [31:0]        emag_reg;
    logic               dneg_reg;
    logic               eneg_reg;
    logic signed [31:0] dist_reg;
    logic [31:0]        dbam_reg;
    logic [31:0]        v_reg;
    logic [31:0]        w_reg;
    logic [63:0]        pt_reg;
    logic [63:0]        den_reg;
    ddo_pkg::crd_t      cs_reg;
    ddo_pkg::crd_t      sn_reg;
    logic signed [31:0] x_reg;
    logic signed [31:0] y_reg;
    logic [31:0]        head_reg;

    ddo_pkg::mop_t      mul_a_reg;
    ddo_pkg::mop_t      mul_b_reg;
    ddo_pkg::mprod_t    mul_init_reg;
    logic               mul_start_reg;
    ddo_pkg::mprod_t    mul_prod;
    logic               mul_done;
    logic [NUM_W-1:0]   div_num_reg;
    ddo_pkg::mop_t      div_den_reg;
    logic               div_start_reg;
    logic [NUM_W-1:0]   div_quo;
    logic               div_done;
    logic               crd_start_reg;
    ddo_pkg::crd_t      crd_cs;
    ddo_pkg::crd_t      crd_sn;
    logic               crd_done;

    logic               m_tvalid_reg;
    logic [159:0]       m_tdata_reg;

    logic [15:0]        in_cl;
    logic [15:0]        in_cr;
    logic [15:0]        cr_mag;
    logic [15:0]        cl_mag;
    logic signed [33:0] term_r;
    logic signed [33:0] term_l;
    logic signed [33:0] d_sum;
    logic signed [33:0] e_sum;
    logic [33:0]        d_abs;
    logic [33:0]        e_abs;
    logic [31:0]        dist_abs;
    logic [NUM_W-1:0]   q_lin;
    logic [NUM_W-1:0]   q_turn;

    function automatic logic [31:0] sat_mag(input logic [NUM_W-1:0] qs, input logic neg);
        logic        over;
        logic [32:0] lim;
        logic [31:0] m;
        lim  = neg ? 33'h080000000 : 33'h07FFFFFFF;
        over = (|qs[NUM_W-1:32]) || ({1'b0, qs[31:0]} > lim);
        m    = over ? lim[31:0] : qs[31:0];
        return neg ? (32'd0 - m) : m;
    endfunction

    function automatic logic [33:0] abs34(input ddo_pkg::crd_t v);
        return v[33] ? 34'(-v) : 34'(v);
    endfunction

    function automatic logic signed [31:0] pos_step(input logic signed [31:0] pos,
                                                    input logic [63:0] mag,
                                                    input logic neg);
        logic signed [65:0] sp;
        logic signed [65:0] rnd;
        logic signed [65:0] sum;
        sp  = neg ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
        rnd = (sp + 66'sd536870912) >>> 30;
        sum = rnd + {{34{pos[31]}}, pos};
        if (sum > 66'sd2147483647)
        begin
            return 32'sh7FFFFFFF;
        end
        else if (sum < -66'sd2147483648)
        begin
            return 32'sh80000000;
        end
        return sum[31:0];
    endfunction

    always_comb
    begin
        in_cl    = s_tdata[15:0];
        in_cr    = s_tdata[31:16];
        cr_mag   = in_cr[15] ? (16'd0 - in_cr) : in_cr;
        cl_mag   = in_cl[15] ? (16'd0 - in_cl) : in_cl;
        term_r   = cr_neg_reg ? -$signed({2'b00, ar_reg}) : $signed({2'b00, ar_reg});
        term_l   = cl_neg_reg ? -$signed({2'b00, mul_prod[31:0]})
                              : $signed({2'b00, mul_prod[31:0]});
        d_sum    = term_r + term_l;
        e_sum    = term_r - term_l;
        d_abs    = d_sum[33] ? 34'(-d_sum) : 34'(d_sum);
        e_abs    = e_sum[33] ? 34'(-e_sum) : 34'(e_sum);
        dist_abs = dist_reg[31] ? (32'd0 - dist_reg) : dist_reg;
        q_lin    = div_quo >> ddo_pkg::SH_LIN;
        q_turn   = div_quo >> ddo_pkg::SH_TURN;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_reg <= 24'd4000;
            rad_r_reg <= 16'd10000;
            rad_l_reg <= 16'd10000;
            tread_reg <= 20'd26214;
        end
        else if (psel && penable && pwrite)
        begin
            case (ddo_pkg::reg_idx_t'(paddr[3:2]))
                ddo_pkg::REG_TICKS:    ticks_reg <= pwdata[23:0];
                ddo_pkg::REG_RADIUS_R: rad_r_reg <= pwdata[15:0];
                ddo_pkg::REG_RADIUS_L: rad_l_reg <= pwdata[15:0];
                ddo_pkg::REG_TREAD:    tread_reg <= pwdata[19:0];
                default:               ticks_reg <= ticks_reg;
            endcase
        end
    end

    always_comb
    begin
        case (ddo_pkg::reg_idx_t'(paddr[3:2]))
            ddo_pkg::REG_TICKS:    prdata = 32'(ticks_reg);
            ddo_pkg::REG_RADIUS_R: prdata = 32'(rad_r_reg);
            ddo_pkg::REG_RADIUS_L: prdata = 32'(rad_l_reg);
            ddo_pkg::REG_TREAD:    prdata = 32'(tread_reg);
            default:               prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mul_start_reg <= 1'b0;
            div_start_reg <= 1'b0;
            crd_start_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            m_tdata_reg   <= '0;
            x_reg         <= '0;
            y_reg         <= '0;
            head_reg      <= '0;
            cl_neg_reg    <= 1'b0;
            cr_neg_reg    <= 1'b0;
            cl_mag_reg    <= '0;
            dt_reg        <= '0;
            p_reg         <= '0;
            t_reg         <= '0;
            ar_reg        <= '0;
            dmag_reg      <= '0;
            emag_reg      <= '0;
            dneg_reg      <= 1'b0;
            eneg_reg      <= 1'b0;
            dist_reg      <= '0;
            dbam_reg      <= '0;
            v_reg         <= '0;
            w_reg         <= '0;
            pt_reg        <= '0;
            den_reg       <= '0;
            cs_reg        <= '0;
            sn_reg        <= '0;
            mul_a_reg     <= '0;
            mul_b_reg     <= '0;
            mul_init_reg  <= '0;
            div_num_reg   <= '0;
            div_den_reg   <= '0;
        end
        else
        begin
            mul_start_reg <= 1'b0;
            div_start_reg <= 1'b0;
            crd_start_reg <= 1'b0;
            if (m_tvalid_reg && m_tready && (state_reg != ST_OUT))
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        cl_neg_reg    <= in_cl[15];
                        cr_neg_reg    <= in_cr[15];
                        cl_mag_reg    <= cl_mag;
                        dt_reg        <= s_tdata[51:32];
                        p_reg         <= (ticks_reg == 24'd0) ? 24'd1 : ticks_reg;
                        t_reg         <= (tread_reg == 20'd0) ? 20'd1 : tread_reg;
                        mul_a_reg     <= 64'(rad_r_reg);
                        mul_b_reg     <= 64'(cr_mag);
                        mul_init_reg  <= '0;
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_MUL_R;
                    end
                end
                ST_MUL_R:
                begin
                    if (mul_done)
                    begin
                        ar_reg        <= mul_prod[31:0];
                        mul_a_reg     <= 64'(rad_l_reg);
                        mul_b_reg     <= 64'(cl_mag_reg);
                        mul_init_reg  <= '0;
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_MUL_L;
                    end
                end
                ST_MUL_L:
                begin
                    if (mul_done)
                    begin
                        state_reg <= ST_SUMS;
                    end
                end
                ST_SUMS:
                begin
                    dmag_reg      <= d_abs[31:0];
                    emag_reg      <= e_abs[31:0];
                    dneg_reg      <= d_sum[33];
                    eneg_reg      <= e_sum[33];
                    mul_a_reg     <= 64'(d_abs[31:0]);
                    mul_b_reg     <= PIF;
                    mul_init_reg  <= 128'(p_reg) << (ddo_pkg::SH_LIN - 1);
                    mul_start_reg <= 1'b1;
                    state_reg     <= ST_DIST_MUL;
                end
                ST_DIST_MUL:
                begin
                    if (mul_done)
                    begin
                        div_num_reg   <= mul_prod[NUM_W-1:0];
                        div_den_reg   <= 64'(p_reg);
                        div_start_reg <= 1'b1;
                        state_reg     <= ST_DIST_DIV;
                    end
                end
                ST_DIST_DIV:
                begin
                    if (div_done)
                    begin
                        dist_reg      <= sat_mag(q_lin, dneg_reg);
                        mul_a_reg     <= 64'(p_reg);
                        mul_b_reg     <= 64'(t_reg);
                        mul_init_reg  <= '0;
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_PT_MUL;
                    end
                end
                ST_PT_MUL:
                begin
                    if (mul_done)
                    begin
                        pt_reg        <= mul_prod[63:0];
                        div_num_reg   <= NUM_W'({emag_reg, 32'd0});
                        div_den_reg   <= mul_prod[63:0];
                        div_start_reg <= 1'b1;
                        state_reg     <= ST_BAM_DIV;
                    end
                end
                ST_BAM_DIV:
                begin
                    if (div_done)
                    begin
                        dbam_reg <= eneg_reg ? (32'd0 - div_quo[31:0]) : div_quo[31:0];
                        if (dt_reg == 20'd0)
                        begin
                            v_reg         <= '0;
                            w_reg         <= '0;
                            crd_start_reg <= 1'b1;
                            state_reg     <= ST_CORDIC;
                        end
                        else
                        begin
                            mul_a_reg     <= 64'(p_reg);
                            mul_b_reg     <= 64'(dt_reg);
                            mul_init_reg  <= '0;
                            mul_start_reg <= 1'b1;
                            state_reg     <= ST_PD_MUL;
                        end
                    end
                end
                ST_PD_MUL:
                begin
                    if (mul_done)
                    begin
                        den_reg       <= mul_prod[63:0];
                        mul_a_reg     <= 64'(dmag_reg);
                        mul_b_reg     <= 64'(ddo_pkg::USEC_PER_SEC);
                        mul_init_reg  <= '0;
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_AV_MUL;
                    end
                end
                ST_AV_MUL:
                begin
                    if (mul_done)
                    begin
                        mul_a_reg     <= mul_prod[63:0];
                        mul_b_reg     <= PIF;
                        mul_init_reg  <= 128'(den_reg) << (ddo_pkg::SH_LIN - 1);
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_V_MUL;
                    end
                end
                ST_V_MUL:
                begin
                    if (mul_done)
                    begin
                        div_num_reg   <= mul_prod[NUM_W-1:0];
                        div_den_reg   <= den_reg;
                        div_start_reg <= 1'b1;
                        state_reg     <= ST_V_DIV;
                    end
                end
                ST_V_DIV:
                begin
                    if (div_done)
                    begin
                        v_reg         <= sat_mag(q_lin, dneg_reg);
                        mul_a_reg     <= pt_reg;
                        mul_b_reg     <= 64'(dt_reg);
                        mul_init_reg  <= '0;
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_PTD_MUL;
                    end
                end
                ST_PTD_MUL:
                begin
                    if (mul_done)
                    begin
                        den_reg       <= mul_prod[63:0];
                        mul_a_reg     <= 64'(emag_reg);
                        mul_b_reg     <= 64'(ddo_pkg::USEC_PER_SEC);
                        mul_init_reg  <= '0;
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_AW_MUL;
                    end
                end
                ST_AW_MUL:
                begin
                    if (mul_done)
                    begin
                        mul_a_reg     <= mul_prod[63:0];
                        mul_b_reg     <= PIF2;
                        mul_init_reg  <= 128'(den_reg) << (ddo_pkg::SH_TURN - 1);
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_W_MUL;
                    end
                end
                ST_W_MUL:
                begin
                    if (mul_done)
                    begin
                        div_num_reg   <= mul_prod[NUM_W-1:0];
                        div_den_reg   <= den_reg;
                        div_start_reg <= 1'b1;
                        state_reg     <= ST_W_DIV;
                    end
                end
                ST_W_DIV:
                begin
                    if (div_done)
                    begin
                        w_reg         <= sat_mag(q_turn, eneg_reg);
                        crd_start_reg <= 1'b1;
                        state_reg     <= ST_CORDIC;
                    end
                end
                ST_CORDIC:
                begin
                    if (crd_done)
                    begin
                        cs_reg        <= crd_cs;
                        sn_reg        <= crd_sn;
                        mul_a_reg     <= 64'(dist_abs);
                        mul_b_reg     <= 64'(abs34(crd_cs));
                        mul_init_reg  <= '0;
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_X_MUL;
                    end
                end
                ST_X_MUL:
                begin
                    if (mul_done)
                    begin
                        x_reg <= pos_step(x_reg, mul_prod[63:0], dist_reg[31] ^ cs_reg[33]);
                        mul_a_reg     <= 64'(dist_abs);
                        mul_b_reg     <= 64'(abs34(sn_reg));
                        mul_init_reg  <= '0;
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_Y_MUL;
                    end
                end
                ST_Y_MUL:
                begin
                    if (mul_done)
                    begin
                        y_reg <= pos_step(y_reg, mul_prod[63:0], dist_reg[31] ^ sn_reg[33]);
                        head_reg  <= head_reg + dbam_reg;
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tdata_reg  <= {w_reg, v_reg, head_reg, y_reg, x_reg};
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    ddo_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start_reg),
        .a     (mul_a_reg),
        .b     (mul_b_reg),
        .init  (mul_init_reg),
        .prod  (mul_prod),
        .done  (mul_done)
    );

    ddo_div #(
        .NUM_W (NUM_W)
    ) u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start_reg),
        .num   (div_num_reg),
        .den   (div_den_reg),
        .quo   (div_quo),
        .done  (div_done)
    );

    ddo_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (crd_start_reg),
        .heading (head_reg),
        .cs      (crd_cs),
        .sn      (crd_sn),
        .done    (crd_done)
    );

    assign pready   = 1'b1;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the differential drive odometry block.
`timescale 1ns / 100ps

module tb_top;

    typedef struct {
        logic [15:0] left;
        logic [15:0] right;
        logic [19:0] interval;
        bit          known;
        logic [159:0] pose;
    } stim_row_t;

    logic         clk;
    logic         rst_n;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [3:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;
    logic         s_tvalid;
    logic         s_tready;
    logic [55:0]  s_tdata;   // left_count, right_count, interval_us, zero fill
    logic         m_tvalid;
    logic         m_tready;
    logic [159:0] m_tdata;   // pos_x, pos_y, heading, linear_speed, turn_rate

    logic [23:0] cfg_ticks;
    logic [15:0] cfg_rad_r;
    logic [15:0] cfg_rad_l;
    logic [19:0] cfg_tread;
    logic signed [31:0] odo_x;
    logic signed [31:0] odo_y;
    logic [31:0] odo_heading;

    logic [159:0] pose_queue[$];
    int  fail_count;
    int  result_count;
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  recv_hold;
    bit  pressure_go;

    differential_drive_odometry u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #4 clk = ~clk;

    // Quotient of a*b by c1*c2*2^sh, rounded with ties up when sh is positive and truncated when sh is zero.
    function automatic logic [127:0] scaled_quot(logic [63:0] a, logic [63:0] b,
                                                 logic [63:0] c1, logic [63:0] c2, int sh);
        logic [127:0] num;
        logic [127:0] den;
        num = 128'(a) * 128'(b);
        den = 128'(c1) * 128'(c2);
        if (sh > 0)
        begin
            num = num + (den << (sh - 1));
        end
        num = num / 128'(c1);
        num = num / 128'(c2);
        return num >> sh;
    endfunction

    function automatic longint clamp_mag(logic [127:0] mag, bit neg);
        logic [127:0] lim;
        lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
        if (mag > lim)
        begin
            mag = lim;
        end
        return neg ? -longint'(mag[63:0]) : longint'(mag[63:0]);
    endfunction

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647)
        begin
            return 32'sh7FFF_FFFF;
        end
        if (v < -64'sd2147483648)
        begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    task automatic heading_trig(input logic [31:0] h, output longint cs, output longint sn);
        longint z;
        longint cx;
        longint cy;
        longint tmp;
        bit flip;
        z = longint'($signed(h));
        cx = longint'(ddo_pkg::GAIN_Q30);
        cy = 0;
        flip = 0;
        if (z > 64'sh4000_0000)
        begin
            z = z - 64'sh8000_0000;
            flip = 1;
        end
        else if (z < -64'sh4000_0000)
        begin
            z = z + 64'sh8000_0000;
            flip = 1;
        end
        for (int i = 0; i < ddo_pkg::CORDIC_STEPS_DEF; i++)
        begin
            if (z >= 0)
            begin
                tmp = cx - (cy >>> i);
                cy = cy + (cx >>> i);
                cx = tmp;
                z = z - longint'(ddo_pkg::ATAN_BAM[i]);
            end
            else
            begin
                tmp = cx + (cy >>> i);
                cy = cy - (cx >>> i);
                cx = tmp;
                z = z + longint'(ddo_pkg::ATAN_BAM[i]);
            end
        end
        cs = flip ? -cx : cx;
        sn = flip ? -cy : cy;
    endtask

    task automatic advance_pose(input logic [15:0] lc, input logic [15:0] rc,
                                input logic [19:0] dt, output logic [159:0] pose);
        logic [63:0] p;
        logic [63:0] t;
        logic [63:0] pif;
        logic [63:0] dmag;
        logic [63:0] emag;
        logic [31:0] dbam;
        longint d;
        longint e;
        longint step_len;
        longint v;
        longint w;
        longint cs;
        longint sn;
        p = (cfg_ticks == 0) ? 64'd1 : 64'(cfg_ticks);
        t = (cfg_tread == 0) ? 64'd1 : 64'(cfg_tread);
        pif = (ddo_pkg::PI_Q60 + (64'd1 << 23)) >> 24;
        d = longint'(cfg_rad_r) * longint'($signed(rc)) + longint'(cfg_rad_l) * longint'($signed(lc));
        e = longint'(cfg_rad_r) * longint'($signed(rc)) - longint'(cfg_rad_l) * longint'($signed(lc));
        dmag = (d < 0) ? -d : d;
        emag = (e < 0) ? -e : e;
        step_len = clamp_mag(scaled_quot(dmag, pif, p, 64'd1, ddo_pkg::SH_LIN), d < 0);
        dbam = 32'(scaled_quot(emag, 64'h1_0000_0000, p, t, 0));
        if (e < 0)
        begin
            dbam = -dbam;
        end
        v = 0;
        w = 0;
        if (dt != 0)
        begin
            v = clamp_mag(scaled_quot(dmag * 64'd1000000, pif, p, 64'(dt), ddo_pkg::SH_LIN),
                          d < 0);
            w = clamp_mag(scaled_quot(emag * 64'd1000000, 2 * pif, p * t, 64'(dt),
                                      ddo_pkg::SH_TURN), e < 0);
        end
        heading_trig(odo_heading, cs, sn);
        odo_x = clamp32(longint'(odo_x) + ((step_len * cs + (64'sd1 <<< 29)) >>> 30));
        odo_y = clamp32(longint'(odo_y) + ((step_len * sn + (64'sd1 <<< 29)) >>> 30));
        odo_heading = odo_heading + dbam;
        pose = {w[31:0], v[31:0], odo_heading, odo_y, odo_x};
    endtask

    task automatic reg_write(input ddo_pkg::reg_idx_t idx, input logic [31:0] val);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            ddo_pkg::REG_TICKS:    cfg_ticks = val[23:0];
            ddo_pkg::REG_RADIUS_R: cfg_rad_r = val[15:0];
            ddo_pkg::REG_RADIUS_L: cfg_rad_l = val[15:0];
            default:               cfg_tread = val[19:0];
        endcase
        @(posedge clk);
    endtask

    task automatic set_geometry(input logic [31:0] ticks, input logic [31:0] rr,
                                input logic [31:0] rl, input logic [31:0] tread);
        reg_write(ddo_pkg::REG_TICKS, ticks);
        reg_write(ddo_pkg::REG_RADIUS_R, rr);
        reg_write(ddo_pkg::REG_RADIUS_L, rl);
        reg_write(ddo_pkg::REG_TREAD, tread);
    endtask

    task automatic send_sample(input logic [15:0] lc, input logic [15:0] rc,
                               input logic [19:0] dt, input bit known,
                               input logic [159:0] typed_pose);
        logic [159:0] pose;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {4'd0, dt, rc, lc};
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        advance_pose(lc, rc, dt, pose);
        pose_queue.push_back(known ? typed_pose : pose);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pose_queue.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (pose_queue.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $time, m_tdata);
                    fail_count++;
                end
                else
                begin
                    logic [159:0] want;
                    string names[5];
                    names = '{"pos_x", "pos_y", "heading", "linear_speed", "turn_rate"};
                    want = pose_queue.pop_front();
                    for (int f = 0; f < 5; f++)
                    begin
                        if (want[f*32 +: 32] !== m_tdata[f*32 +: 32])
                        begin
                            $display("%0t: %s expected %h actual %h", $time, names[f],
                                     want[f*32 +: 32], m_tdata[f*32 +: 32]);
                            fail_count++;
                        end
                    end
                end
                result_count++;
            end
            m_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        wait (pressure_go);
        @(posedge clk);
        recv_hold <= 1'b1;
        repeat (3000) @(posedge clk);
        recv_hold <= 1'b0;
    end

    initial
    begin
        #40ms;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        stim_row_t rows[$];
        logic [15:0] lc;
        logic [15:0] rc;
        logic [19:0] dt;
        clk = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        recv_hold = 1'b0;
        pressure_go = 1'b0;
        fail_count = 0;
        result_count = 0;
        send_idle_pct = 18;
        recv_idle_pct = 69;
        cfg_ticks = 24'd4000;
        cfg_rad_r = 16'd10000;
        cfg_rad_l = 16'd10000;
        cfg_tread = 20'd26214;
        odo_x = 0;
        odo_y = 0;
        odo_heading = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        rows = '{
            '{16'h0000, 16'h0000, 20'd1000,    1'b1, 160'd0},
            '{16'h0000, 16'h0000, 20'd0,       1'b1, 160'd0},
            '{16'h7FFF, 16'h7FFF, 20'd1000,    1'b0, 160'd0},
            '{16'h8000, 16'h8000, 20'd1000,    1'b0, 160'd0},
            '{16'h7FFF, 16'h8000, 20'd1,       1'b0, 160'd0},
            '{16'h8000, 16'h7FFF, 20'hFFFFF,   1'b0, 160'd0},
            '{16'd100,  -16'd100, 20'd0,       1'b0, 160'd0},
            '{16'd4000, 16'd4000, 20'd1000000, 1'b0, 160'd0},
            '{16'd1000, 16'd0,    20'd20000,   1'b0, 160'd0},
            '{16'd0,    16'd1000, 20'd20000,   1'b0, 160'd0},
            '{-16'd1,   16'd1,    20'd1,       1'b0, 160'd0},
            '{16'd1,    -16'd1,   20'hFFFFF,   1'b0, 160'd0},
            '{16'd5000, -16'd5000, 20'd100,    1'b0, 160'd0},
            '{16'd5000, -16'd5000, 20'd100,    1'b0, 160'd0},
            '{16'd5000, -16'd5000, 20'd100,    1'b0, 160'd0},
            '{16'd5000, -16'd5000, 20'd100,    1'b0, 160'd0},
            '{16'h5555, 16'hAAAA, 20'h55555,   1'b0, 160'd0},
            '{16'hAAAA, 16'h5555, 20'hAAAAA,   1'b0, 160'd0},
            '{16'd3000, 16'd2000, 20'd10000,   1'b0, 160'd0}
        };
        foreach (rows[r])
        begin
            send_sample(rows[r].left, rows[r].right, rows[r].interval,
                        rows[r].known, rows[r].pose);
        end
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: set_geometry(32'd1, 32'd65535, 32'd65535, 32'd1);
                1: set_geometry(32'd0, 32'd1, 32'd1, 32'd0);
                2: set_geometry(32'd16777215, 32'd1, 32'd65535, 32'd1048575);
                3: set_geometry(32'd4000, 32'd10000, 32'd10000, 32'd26214);
                default: set_geometry($urandom_range(1, 24'hFFFFFF), $urandom_range(1, 65535),
                                      $urandom_range(1, 65535), $urandom_range(1, 20'hFFFFF));
            endcase
            send_idle_pct = (ph % 3 == 0) ? 18 : (ph % 3 == 1) ? 69 : 0;
            recv_idle_pct = (ph % 3 == 0) ? 69 : (ph % 3 == 1) ? 18 : 0;
            if (ph == 3)
            begin
                pressure_go = 1'b1;
            end
            for (int n = 0; n < 250; n++)
            begin
                if ($urandom_range(99) < 70)
                begin
                    lc = 16'($urandom_range(4000)) - 16'd2000;
                    rc = 16'($urandom_range(4000)) - 16'd2000;
                    dt = 20'($urandom_range(1000, 50000));
                end
                else
                begin
                    lc = 16'($urandom);
                    rc = 16'($urandom);
                    dt = 20'($urandom_range(0, 20'hFFFFF));
                end
                send_sample(lc, rc, dt, 1'b0, 160'd0);
            end
            drain();
        end

        repeat (600) @(posedge clk);
        $display("Checked %0d odometry results over seven wheel geometries,", result_count);
        $display("including zero and extreme registers, saturation and output back-pressure.");
        if (fail_count == 0 && pose_queue.size() == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
